@@ sv/sv39w_pkg.sv @@
// Shared types, status codes and controller/datapath bundles for the Sv39 table walker.
package sv39w_pkg;

    localparam int VA_W   = 39;
    localparam int PA_W   = 56;
    localparam int PPN_W  = 44;
    localparam int PERM_W = 10;
    localparam int PTE_W  = 64;
    localparam int VPN_W  = 9;
    localparam int OFF_W  = 12;

    typedef logic [2:0] t_status;

    localparam t_status ST_OK         = 3'd0;
    localparam t_status ST_MISALIGNED = 3'd1;
    localparam t_status ST_VA_RANGE   = 3'd2;
    localparam t_status ST_NO_TABLE   = 3'd3;
    localparam t_status ST_NO_FRAME   = 3'd4;
    localparam t_status ST_MAPPED     = 3'd5;

    typedef struct packed {
        logic    load_req;
        logic    rd_en;
        logic    clr_en;
        logic    load_frame;
        logic    alloc_wr;
        logic    leaf_wr;
        logic    ld_result;
        t_status status;
    } t_dp_cmd;

    typedef struct packed {
        logic misaligned;
        logic va_range;
        logic is_map;
        logic pte_valid;
        logic ptr_ok;
        logic frames_full;
        logic leaf_level;
        logic clr_done;
    } t_dp_sts;

endpackage

@@ sv/sv39w_intf.sv @@
// Request and response channel interfaces of the Sv39 table walker.
interface sv39w_req_if;
    logic                        valid;
    logic                        ready;
    logic                        func;
    logic [sv39w_pkg::VA_W-1:0]   virtual_address;
    logic [sv39w_pkg::PA_W-1:0]   physical_address;
    logic [sv39w_pkg::PERM_W-1:0] permission_bits;

    modport source (output valid, func, virtual_address, physical_address, permission_bits,
                    input ready);
    modport sink (input valid, func, virtual_address, physical_address, permission_bits,
                  output ready);
endinterface

interface sv39w_rsp_if;
    logic                       valid;
    logic                       ready;
    sv39w_pkg::t_status          status;
    logic [sv39w_pkg::PTE_W-1:0] leaf_entry;

    modport source (output valid, status, leaf_entry, input ready);
    modport sink (input valid, status, leaf_entry, output ready);
endinterface

@@ sv/sv39w_dp.sv @@
// Datapath of the Sv39 table walker: request registers, table store, pointer decode, result register.
module sv39w_dp #(
    parameter int TABLE_FRAMES = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  sv39w_pkg::t_dp_cmd           i_cmd,
    output sv39w_pkg::t_dp_sts           o_sts,
    input  logic [sv39w_pkg::PA_W-1:0]   i_base,
    input  logic                         i_func,
    input  logic [sv39w_pkg::VA_W-1:0]   i_va,
    input  logic [sv39w_pkg::PA_W-1:0]   i_pa,
    input  logic [sv39w_pkg::PERM_W-1:0] i_perm,
    output sv39w_pkg::t_status           o_status,
    output logic [sv39w_pkg::PTE_W-1:0]  o_leaf
);

    localparam int FW    = $clog2(TABLE_FRAMES);
    localparam int CW    = $clog2(TABLE_FRAMES + 1);
    localparam int DEPTH = TABLE_FRAMES * 512;
    localparam int AW    = FW + sv39w_pkg::VPN_W;

    logic                         r_func;
    logic [sv39w_pkg::VA_W-1:0]   r_va;
    logic [sv39w_pkg::PA_W-1:0]   r_pa;
    logic [sv39w_pkg::PERM_W-1:0] r_perm;
    logic [1:0]                   r_level;
    logic [FW-1:0]                r_frame;
    logic [CW-1:0]                r_frames_in_use;
    logic [AW-1:0]                r_clr_addr;
    logic [sv39w_pkg::PTE_W-1:0]  r_rdata;
    logic [sv39w_pkg::PTE_W-1:0]  r_mem [DEPTH];
    sv39w_pkg::t_status           r_out_status;
    logic [sv39w_pkg::PTE_W-1:0]  r_out_leaf;

    logic [sv39w_pkg::VPN_W-1:0]  w_vpn;
    logic [AW-1:0]                w_addr;
    logic                         w_we;
    logic [sv39w_pkg::PTE_W-1:0]  w_wdata;
    logic [sv39w_pkg::PPN_W-1:0]  w_base_ppn;
    logic [sv39w_pkg::PPN_W:0]    w_diff;
    logic [sv39w_pkg::PPN_W-1:0]  w_alloc_ppn;
    logic [sv39w_pkg::PTE_W-1:0]  w_alloc_pte;
    logic [sv39w_pkg::PTE_W-1:0]  w_new_leaf;
    logic [FW-1:0]                w_new_frame;

    always_comb begin
        case (r_level)
            2'd2:    w_vpn = r_va[38:30];
            2'd1:    w_vpn = r_va[29:21];
            default: w_vpn = r_va[20:12];
        endcase
    end

    assign w_base_ppn  = i_base[sv39w_pkg::PA_W-1:sv39w_pkg::OFF_W];
    assign w_diff      = {1'b0, r_rdata[53:10]} - {1'b0, w_base_ppn};
    assign w_new_frame = r_frames_in_use[FW-1:0];
    assign w_alloc_ppn = w_base_ppn + sv39w_pkg::PPN_W'(w_new_frame);
    assign w_alloc_pte = {10'd0, w_alloc_ppn, 9'd0, 1'b1};
    assign w_new_leaf  = {10'd0, r_pa[sv39w_pkg::PA_W-1:sv39w_pkg::OFF_W], r_perm[9:1], 1'b1};

    assign w_addr  = i_cmd.clr_en ? r_clr_addr : {r_frame, w_vpn};
    assign w_we    = i_cmd.clr_en | i_cmd.alloc_wr | i_cmd.leaf_wr;
    assign w_wdata = i_cmd.clr_en   ? '0 :
                     i_cmd.alloc_wr ? w_alloc_pte : w_new_leaf;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_addr] <= w_wdata;
        end
        if (i_cmd.rd_en) begin
            r_rdata <= r_mem[w_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frames_in_use <= CW'(1);
            r_clr_addr      <= '0;
        end else begin
            if (i_cmd.clr_en) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            if (i_cmd.alloc_wr) begin
                r_frames_in_use <= r_frames_in_use + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_func  <= i_func;
            r_va    <= i_va;
            r_pa    <= i_pa;
            r_perm  <= i_perm;
            r_level <= 2'd2;
            r_frame <= '0;
        end else if (i_cmd.load_frame) begin
            r_frame <= w_diff[FW-1:0];
            r_level <= r_level - 2'd1;
        end else if (i_cmd.alloc_wr) begin
            r_frame <= w_new_frame;
            r_level <= r_level - 2'd1;
        end
        if (i_cmd.ld_result) begin
            r_out_status <= i_cmd.status;
            if (i_cmd.status != sv39w_pkg::ST_OK) begin
                r_out_leaf <= '0;
            end else if (r_func) begin
                r_out_leaf <= w_new_leaf;
            end else begin
                r_out_leaf <= r_rdata;
            end
        end
    end

    assign o_sts.misaligned  = r_func && ((r_va[11:0] != 12'd0) || (r_pa[11:0] != 12'd0));
    assign o_sts.va_range    = r_va[38];
    assign o_sts.is_map      = r_func;
    assign o_sts.pte_valid   = r_rdata[0];
    assign o_sts.ptr_ok      = !w_diff[sv39w_pkg::PPN_W]
                               && (w_diff[sv39w_pkg::PPN_W-1:0]
                                   < sv39w_pkg::PPN_W'(r_frames_in_use));
    assign o_sts.frames_full = (r_frames_in_use == CW'(TABLE_FRAMES));
    assign o_sts.leaf_level  = (r_level == 2'd0);
    assign o_sts.clr_done    = (r_clr_addr == AW'(DEPTH - 1));

    assign o_status = r_out_status;
    assign o_leaf   = r_out_leaf;

endmodule

@@ sv/sv39w_ctrl.sv @@
// Controller of the Sv39 table walker: clearing sweep, walk sequencing and result handshake.
module sv39w_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_req_valid,
    output logic               o_req_ready,
    input  logic               i_rsp_ready,
    output logic               o_rsp_valid,
    input  sv39w_pkg::t_dp_sts i_sts,
    output sv39w_pkg::t_dp_cmd o_cmd
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_CHECK = 3'd2;
    localparam logic [2:0] S_EVAL  = 3'd3;
    localparam logic [2:0] S_ISSUE = 3'd4;
    localparam logic [2:0] S_ALLOC = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0]         r_state;
    logic [2:0]         n_state;
    sv39w_pkg::t_status r_code;
    sv39w_pkg::t_status n_code;
    logic               r_out_valid;
    logic               n_out_valid;

    always_comb begin
        n_state = r_state;
        n_code  = r_code;
        o_cmd   = '0;
        o_cmd.status = r_code;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_en = 1'b1;
                if (i_sts.clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.load_req = 1'b1;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_sts.misaligned) begin
                    n_code  = sv39w_pkg::ST_MISALIGNED;
                    n_state = S_DONE;
                end else if (i_sts.va_range) begin
                    n_code  = sv39w_pkg::ST_VA_RANGE;
                    n_state = S_DONE;
                end else begin
                    o_cmd.rd_en = 1'b1;
                    n_state = S_EVAL;
                end
            end
            S_ISSUE: begin
                o_cmd.rd_en = 1'b1;
                n_state = S_EVAL;
            end
            S_EVAL: begin
                n_state = S_DONE;
                if (i_sts.leaf_level) begin
                    if (i_sts.is_map && i_sts.pte_valid) begin
                        n_code = sv39w_pkg::ST_MAPPED;
                    end else begin
                        o_cmd.leaf_wr = i_sts.is_map;
                        n_code = sv39w_pkg::ST_OK;
                    end
                end else if (i_sts.pte_valid) begin
                    if (i_sts.ptr_ok) begin
                        o_cmd.load_frame = 1'b1;
                        n_state = S_ISSUE;
                    end else begin
                        n_code = sv39w_pkg::ST_NO_TABLE;
                    end
                end else if (!i_sts.is_map) begin
                    n_code = sv39w_pkg::ST_NO_TABLE;
                end else if (i_sts.frames_full) begin
                    n_code = sv39w_pkg::ST_NO_FRAME;
                end else begin
                    n_state = S_ALLOC;
                end
            end
            S_ALLOC: begin
                o_cmd.alloc_wr = 1'b1;
                n_state = S_ISSUE;
            end
            S_DONE: begin
                if (!r_out_valid || i_rsp_ready) begin
                    o_cmd.ld_result = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.ld_result) begin
            n_out_valid = 1'b1;
        end else if (i_rsp_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_code      <= sv39w_pkg::ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_code      <= n_code;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_req_ready = (r_state == S_IDLE);
    assign o_rsp_valid = r_out_valid;

endmodule

@@ sv/sv39_page_table_walk_and_map_top.sv @@
// Top level of the Sv39 three-level page table walker and mapper.
// After reset the block clears all TABLE_FRAMES * 512 entries of its table store, one entry
// per cycle, and accepts no request until that pass ends (configuration writes are taken at
// any time). A lookup walks the levels in turn: the check state issues the level-2 read, each
// level then evaluates its registered entry in an evaluate state, with an issue state that
// addresses each lower level, and a done state loads the result register. A map inserts an
// alloc state for each intermediate frame it allocates. A request that fails its checks or
// finds a table missing ends its walk early. These steps follow from the single-port table
// store. The next request can be accepted in the cycle after the result register is loaded.
// A finished result waits in an output register, so a new request is accepted while it is
// pending; a walk that finishes while the previous result is still pending holds in its done
// state until that one is taken.
// Status 0 is ok, 1 misaligned, 2 address out of range, 3 table missing, 4 out of frames and
// 5 already mapped; the leaf entry is zero whenever the status is not ok.
module sv39_page_table_walk_and_map_top #(
    parameter int TABLE_FRAMES = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    sv39w_req_if.sink           i_req,
    sv39w_rsp_if.source         o_rsp,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [63:0]         pwdata,
    output logic [63:0]         prdata,
    output logic                pready
);

    logic [sv39w_pkg::PA_W-1:0] r_base;
    sv39w_pkg::t_dp_cmd         w_cmd;
    sv39w_pkg::t_dp_sts         w_sts;
    logic                       w_req_ready;
    logic                       w_rsp_valid;

    assign pready = 1'b1;
    assign prdata = paddr[3] ? 64'd0 : {8'd0, r_base};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= sv39w_pkg::PA_W'(64'h8000_0000);
        end else if (psel && penable && pwrite && !paddr[3]) begin
            r_base <= pwdata[sv39w_pkg::PA_W-1:0];
        end
    end

    sv39w_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (w_req_ready),
        .i_rsp_ready (o_rsp.ready),
        .o_rsp_valid (w_rsp_valid),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    sv39w_dp #(
        .TABLE_FRAMES (TABLE_FRAMES)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .o_sts    (w_sts),
        .i_base   (r_base),
        .i_func   (i_req.func),
        .i_va     (i_req.virtual_address),
        .i_pa     (i_req.physical_address),
        .i_perm   (i_req.permission_bits),
        .o_status (o_rsp.status),
        .o_leaf   (o_rsp.leaf_entry)
    );

    assign i_req.ready = w_req_ready;
    assign o_rsp.valid = w_rsp_valid;

endmodule
